// ===== hw/rtl/lmph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter package
// Shared constants, the log2 fraction table, the log stage payload type and
// the configuration type of the level meter with peak hold.
// ----------------------------------------------------------------------------
package lmph_pkg;

   localparam int FLOOR_DB = 48;
   localparam int LOG_MANTISSA_BITS = 6;
   localparam int MANT_SIZE = 1 << LOG_MANTISSA_BITS;

   localparam int AMP_W = 16;
   localparam int FRAC_W = 13;
   localparam int HOLD_W = 8;
   localparam int SEG_W = 7;
   localparam int PSEG_W = 6;
   localparam int LOG_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 2'd2;

   localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 8'd33;
   localparam logic [FRAC_W-1:0] FALL_STEP_RESET = 13'd164;
   localparam logic [SEG_W-1:0] SEGMENT_COUNT_RESET = 7'd16;

   localparam logic [FRAC_W-1:0] FULL_Q12 = 13'd4096;
   localparam logic [SEG_W-1:0] SEG_MAX = 7'd64;
   localparam logic [AMP_W-1:0] SILENCE_MAX = 16'd3;

   localparam int Y_W = 42;
   localparam longint DB_PER_OCTAVE_Q16 = 394566;
   localparam longint FLOOR_BIAS = longint'(FLOOR_DB) * 64'h1_0000_0000;
   localparam longint ROUND_BIAS = longint'(FLOOR_DB) * 64'h8_0000;
   localparam longint Y_MAX = DB_PER_OCTAVE_Q16 * 65536 + FLOOR_BIAS + ROUND_BIAS;
   localparam int Z_W = $clog2((Y_MAX >> 20) + 1);
   localparam longint SAT_Z = 4096 * longint'(FLOOR_DB);
   localparam int RECIP_SHIFT = 32;
   localparam longint RECIP = (64'h1_0000_0000 + longint'(FLOOR_DB) - 1) / FLOOR_DB;
   localparam longint L2_OFFSET = 15 * 65536;

   typedef logic [LOG_W-1:0] log_tab_type [MANT_SIZE];

   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] x;
      logic [16:0] r;
      logic [17:0] rr;
      for (int k = 0; k < MANT_SIZE; k++) begin
         x = (64'd1 << 30) + (64'(k) << (30 - LOG_MANTISSA_BITS));
         r = '0;
         for (int i = 0; i < 17; i++) begin
            x = (x * x) >> 30;
            r = {r[15:0], (x >= (64'd1 << 31))};
            if (x >= (64'd1 << 31)) begin
               x = x >> 1;
            end
         end
         rr = 18'(r) + 18'd1;
         tab[k] = rr[17:1];
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

   typedef struct packed {
      logic           zero;
      logic [Z_W-1:0] z;
   } log_type;

   typedef struct packed {
      logic [HOLD_W-1:0] hold_ticks;
      logic [FRAC_W-1:0] fall_step;
      logic [SEG_W-1:0]  segment_count;
   } cfg_type;

endpackage

// ===== hw/rtl/level_meter_peak_hold_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter with peak hold, top level
// Maps each amplitude to a Q12 meter fraction, tracks a held peak and gives
// the LED ladder outputs. Holds the input register and the control registers.
// ----------------------------------------------------------------------------
// The block takes one amplitude per clock cycle while the results are taken
// (rsp_ready), and gives one result for each. An accepted amplitude passes
// every stage in order before its result is offered. There are four registers: an
// input register, a log stage with the decibel multiply, a scale stage with the
// reciprocal multiply, and the peak stage that updates the held peak and fills
// the result register. Every stage has its own valid bit, so bubbles close up
// and the pipeline only stalls once all stages hold an item and the result is
// not taken. Control registers are written through a plain write port and
// should only change while the pipeline is empty.
module level_meter_peak_hold_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lmph_pkg::AMP_W-1:0]       req_amplitude,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lmph_pkg::FRAC_W-1:0]      rsp_level,
   output logic [lmph_pkg::FRAC_W-1:0]      rsp_peak,
   output logic [lmph_pkg::SEG_W-1:0]       rsp_lit_count,
   output logic [lmph_pkg::PSEG_W-1:0]      rsp_peak_segment,
   output logic                             rsp_peak_marker_on,
   input  logic                             csr_wr_en,
   input  logic [lmph_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lmph_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lmph_pkg::*;

   logic                 amp_valid_ff;
   logic                 amp_valid_in;
   logic [AMP_W-1:0]     amp_ff;
   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 log_ready;
   logic                 log_valid;
   log_type              log_data;
   logic                 scale_ready;
   logic                 scale_valid;
   logic [FRAC_W-1:0]    scale_level;
   logic                 peak_ready;
   logic                 load;

   assign req_ready = !amp_valid_ff || log_ready;
   assign load = req_valid && req_ready;

   always_comb begin
      amp_valid_in = amp_valid_ff;
      if (load) begin
         amp_valid_in = 1'b1;
      end else if (log_ready) begin
         amp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HOLD_TICKS: begin
               cfg_in.hold_ticks = csr_wdata[HOLD_W-1:0];
            end
            CSR_FALL_STEP: begin
               cfg_in.fall_step = csr_wdata[FRAC_W-1:0];
            end
            CSR_SEGMENT_COUNT: begin
               cfg_in.segment_count = csr_wdata[SEG_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_valid_ff <= 1'b0;
         cfg_ff.hold_ticks <= HOLD_TICKS_RESET;
         cfg_ff.fall_step <= FALL_STEP_RESET;
         cfg_ff.segment_count <= SEGMENT_COUNT_RESET;
      end else begin
         amp_valid_ff <= amp_valid_in;
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         amp_ff <= req_amplitude;
      end
   end

   lmph_log_stage u_log (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (amp_valid_ff),
      .in_ready  (log_ready),
      .amplitude (amp_ff),
      .out_valid (log_valid),
      .out_ready (scale_ready),
      .out_data  (log_data)
   );

   lmph_scale_stage u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (log_valid),
      .in_ready  (scale_ready),
      .in_data   (log_data),
      .out_valid (scale_valid),
      .out_ready (peak_ready),
      .level     (scale_level)
   );

   lmph_peak_stage u_peak (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (scale_valid),
      .in_ready           (peak_ready),
      .level              (scale_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_level          (rsp_level),
      .rsp_peak           (rsp_peak),
      .rsp_lit_count      (rsp_lit_count),
      .rsp_peak_segment   (rsp_peak_segment),
      .rsp_peak_marker_on (rsp_peak_marker_on)
   );

endmodule

// ===== hw/rtl/lmph_log_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter log stage
// Takes the log2 of the amplitude from the leading-one position and a table,
// scales it to decibels and adds the floor, and registers the scaled value.
// ----------------------------------------------------------------------------
module lmph_log_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [lmph_pkg::AMP_W-1:0]   amplitude,
   output logic                         out_valid,
   input  logic                         out_ready,
   output lmph_pkg::log_type            out_data
);
   import lmph_pkg::*;

   logic                                 valid_ff;
   logic                                 valid_in;
   log_type                              data_ff;
   log_type                              data_in;
   logic [3:0]                           lead;
   logic [AMP_W+LOG_MANTISSA_BITS-1:0]   shifted;
   logic [LOG_MANTISSA_BITS-1:0]         mant;
   logic [20:0]                          l2;
   logic signed [21:0]                   xs;
   logic signed [Y_W-1:0]                y;
   logic [Y_W-1:0]                       u;
   logic                                 load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      lead = '0;
      for (int i = 0; i < AMP_W; i++) begin
         if (amplitude[i]) begin
            lead = 4'(i);
         end
      end
      shifted = {amplitude, {LOG_MANTISSA_BITS{1'b0}}} >> lead;
      mant = shifted[LOG_MANTISSA_BITS-1:0];
      l2 = 21'({lead, 16'h0000}) + 21'(LOG_TAB[mant]);
      xs = $signed({1'b0, l2}) - 22'(L2_OFFSET);
      y = Y_W'(xs) * Y_W'(DB_PER_OCTAVE_Q16) + Y_W'(FLOOR_BIAS);
      u = unsigned'(y) + Y_W'(ROUND_BIAS);
      data_in.zero = (amplitude <= SILENCE_MAX) || y[Y_W-1] || (y == '0);
      data_in.z = u[20 +: Z_W];
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ===== hw/rtl/lmph_scale_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter scale stage
// Divides the scaled decibel value by the floor through a reciprocal multiply,
// saturates at full scale, gives zero on the zero flag and registers the fraction.
// ----------------------------------------------------------------------------
module lmph_scale_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  lmph_pkg::log_type            in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [lmph_pkg::FRAC_W-1:0]  level
);
   import lmph_pkg::*;

   logic                          valid_ff;
   logic                          valid_in;
   logic [FRAC_W-1:0]             level_ff;
   logic [FRAC_W-1:0]             level_in;
   logic [Z_W+RECIP_SHIFT-1:0]    prod;
   logic                          load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      prod = (Z_W+RECIP_SHIFT)'(in_data.z) * (Z_W+RECIP_SHIFT)'(RECIP);
      if (in_data.zero) begin
         level_in = '0;
      end else if (in_data.z >= Z_W'(SAT_Z)) begin
         level_in = FULL_Q12;
      end else begin
         level_in = prod[RECIP_SHIFT +: FRAC_W];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= level_in;
      end
   end

   assign out_valid = valid_ff;
   assign level = level_ff;

endmodule

// ===== hw/rtl/lmph_peak_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter peak stage
// Updates the held peak and its hold counter, derives the LED ladder
// outputs and holds the result register.
// ----------------------------------------------------------------------------
module lmph_peak_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  lmph_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [lmph_pkg::FRAC_W-1:0]   level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lmph_pkg::FRAC_W-1:0]   rsp_level,
   output logic [lmph_pkg::FRAC_W-1:0]   rsp_peak,
   output logic [lmph_pkg::SEG_W-1:0]    rsp_lit_count,
   output logic [lmph_pkg::PSEG_W-1:0]   rsp_peak_segment,
   output logic                          rsp_peak_marker_on
);
   import lmph_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [FRAC_W-1:0]    peak_ff;
   logic [FRAC_W-1:0]    peak_in;
   logic [HOLD_W-1:0]    hold_ff;
   logic [HOLD_W-1:0]    hold_in;
   logic [FRAC_W-1:0]    level_ff;
   logic [FRAC_W-1:0]    out_peak_ff;
   logic [SEG_W-1:0]     lit_ff;
   logic [SEG_W-1:0]     lit_in;
   logic [PSEG_W-1:0]    pseg_ff;
   logic [PSEG_W-1:0]    pseg_in;
   logic                 marker_ff;
   logic                 marker_in;
   logic [FRAC_W-1:0]    dropped;
   logic [SEG_W-1:0]     seg_n;
   logic [19:0]          lit_prod;
   logic [19:0]          pk_prod;
   logic [SEG_W-1:0]     pk_ceil;
   logic [SEG_W-1:0]     pk_seg_wide;
   logic                 load;

   assign in_ready = !valid_ff || rsp_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      dropped = (peak_ff > cfg.fall_step) ? (peak_ff - cfg.fall_step) : '0;
      peak_in = peak_ff;
      hold_in = hold_ff;
      if (level >= peak_ff) begin
         peak_in = level;
         hold_in = cfg.hold_ticks;
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - 1'b1;
      end else begin
         peak_in = (dropped > level) ? dropped : level;
      end
   end

   always_comb begin
      if (cfg.segment_count == '0) begin
         seg_n = 7'd1;
      end else if (cfg.segment_count > SEG_MAX) begin
         seg_n = SEG_MAX;
      end else begin
         seg_n = cfg.segment_count;
      end
      lit_prod = 20'(level) * 20'(seg_n) + 20'(FULL_Q12 - 1'b1);
      pk_prod = 20'(peak_in) * 20'(seg_n) + 20'(FULL_Q12 - 1'b1);
      lit_in = lit_prod[12 +: SEG_W];
      pk_ceil = pk_prod[12 +: SEG_W];
      pk_seg_wide = pk_ceil - 1'b1;
      if (peak_in != '0) begin
         pseg_in = pk_seg_wide[PSEG_W-1:0];
         marker_in = (pk_seg_wide >= lit_in);
      end else begin
         pseg_in = '0;
         marker_in = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         peak_ff <= '0;
         hold_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            peak_ff <= peak_in;
            hold_ff <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= level;
         out_peak_ff <= peak_in;
         lit_ff <= lit_in;
         pseg_ff <= pseg_in;
         marker_ff <= marker_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_level = level_ff;
   assign rsp_peak = out_peak_ff;
   assign rsp_lit_count = lit_ff;
   assign rsp_peak_segment = pseg_ff;
   assign rsp_peak_marker_on = marker_ff;

   peak_not_below_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak >= rsp_level))
      else $error("held peak below level");

   peak_in_range: assert property (@(posedge clock) disable iff (reset)
      peak_ff <= FULL_Q12)
      else $error("held peak above full scale");

   marker_needs_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_peak_marker_on) |-> (rsp_peak != '0))
      else $error("peak marker shown with zero peak");

endmodule
